// ===== hw/rtl/frc_pkg.sv =====
// shared types and constants for the fraction add/subtract/reduce block
// no dependencies
package frc_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned NumOutWidth     = 33;
  localparam int unsigned DenOutWidth     = 31;
  localparam int unsigned QueueDepth      = 2;

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdSub = 1'b1;

  // classification of one item, decided at the front
  typedef struct packed {
    logic zero_den;
    logic t1_neg;
    logic t2_neg;
    logic den_neg;
  } frc_class_t;

  localparam int unsigned ClassWidth = $bits(frc_class_t);

endpackage

// ===== hw/rtl/fraction_add_sub_reduce.sv =====
// top level of the fraction add/subtract/reduce block
// depends on frc_pkg, frc_front, frc_queue, frc_back
//
// adds or subtracts two signed fractions and returns the sum or difference
// in lowest terms with the sign on the numerator
// input channel s_axis: tdata holds the four operands, tuser the command
// (0 add, 1 subtract second from first); an item is taken on tvalid & tready
// output channel m_axis: tdata holds the reduced numerator and denominator,
// tuser flags a zero input denominator (result then reads 0/0)
// in the back end each item passes through the shared multiplier, the
// iterating binary gcd, the bit-serial dividers and the output register
// a zero denominator item skips the arithmetic
// a two-entry queue lets the input side take items while the back end works
// reset clears the queue, the sequencer and the output valid; a stalled
// receiver holds the result in the output register, the back end waits
// in its final step and the queue fills before s_axis_tready_o drops
module fraction_add_sub_reduce import frc_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // fields from bit 0: first_numerator, first_denominator,
  // second_numerator, second_denominator, zero fill
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // command
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // fields from bit 0: result_numerator, result_denominator
  output logic [63:0] m_axis_tdata_o,
  // zero_denominator_error
  output logic m_axis_tuser_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned QW = ClassWidth + 4 * W;

  // front to queue
  logic             push, full;
  frc_class_t       f_class;
  logic [4*W-1:0]   f_mags;

  // queue to back end
  logic             q_valid, q_pop;
  logic [QW-1:0]    q_data;
  frc_class_t       b_class;

  logic [NumOutWidth-1:0] res_num;
  logic [DenOutWidth-1:0] res_den;

  frc_front #(.OPERAND_WIDTH(W)) u_front (
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .command_i  (s_axis_tuser_i),
    .operands_i (s_axis_tdata_i[4*W-1:0]),
    .full_i     (full),
    .push_o     (push),
    .class_o    (f_class),
    .mags_o     (f_mags)
  );

  frc_queue #(.DATA_WIDTH(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_class, f_mags}),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_data)
  );

  assign b_class = q_data[QW-1 -: ClassWidth];

  frc_back #(.OPERAND_WIDTH(W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .class_i     (b_class),
    .mags_i      (q_data[4*W-1:0]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_num_o   (res_num),
    .out_den_o   (res_den),
    .out_err_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {res_den, res_num};

endmodule

// ===== hw/rtl/frc_front.sv =====
// front end: accepts items, splits operands into sign and magnitude, classifies
// depends on frc_pkg
module frc_front import frc_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic                           command_i,
  input  logic [4*OPERAND_WIDTH-1:0]     operands_i,
  input  logic                           full_i,
  output logic                           push_o,
  output frc_class_t                     class_o,
  output logic [4*OPERAND_WIDTH-1:0]     mags_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic [3:0]   neg;
  logic [W-1:0] mag [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg[i] = operands_i[i*W+W-1];
      mag[i] = neg[i] ? (~operands_i[i*W +: W] + W'(1)) : operands_i[i*W +: W];
    end
  end

  // operand order: a = first num, b = first den, c = second num, d = second den
  always_comb begin
    class_o.zero_den = (mag[1] == '0) || (mag[3] == '0);
    class_o.t1_neg   = neg[0] ^ neg[3];
    class_o.t2_neg   = neg[2] ^ neg[1] ^ (command_i == CmdSub);
    class_o.den_neg  = neg[1] ^ neg[3];
  end

  assign mags_o  = {mag[3], mag[2], mag[1], mag[0]};
  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

endmodule

// ===== hw/rtl/frc_queue.sv =====
// short queue between front and back end
// depends on frc_pkg
module frc_queue import frc_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam int unsigned PW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  logic [DATA_WIDTH-1:0] entry_q [QueueDepth];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(QueueDepth - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(QueueDepth - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= data_i;
  end

  assign full_o  = (cnt_q == CW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rptr_q];

endmodule

// ===== hw/rtl/frc_back.sv =====
// back end: shared multiplier, binary gcd, two exact dividers, output register
// depends on frc_pkg
module frc_back import frc_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  frc_class_t                 class_i,
  input  logic [4*OPERAND_WIDTH-1:0] mags_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [NumOutWidth-1:0]     out_num_o,
  output logic [DenOutWidth-1:0]     out_den_o,
  output logic                       out_err_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned G  = 2 * W + 1;
  localparam int unsigned KW = $clog2(G + 1);
  localparam int unsigned XN = (G > NumOutWidth) ? G : NumOutWidth;
  localparam int unsigned XD = (G > DenOutWidth) ? G : DenOutWidth;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StMul3 = 3'd3;
  localparam logic [2:0] StGcd  = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]    state_q, state_d;
  frc_class_t    cls_q;
  logic [W-1:0]  am_q, bm_q, cm_q, dm_q;
  logic [PW-1:0] t1_q, t2_q;
  logic          nn_q;
  logic [G-1:0]  x_q, y_q, g_q, nsh_q, dsh_q, nrem_q, drem_q;
  logic [KW-1:0] k_q, cnt_q;

  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [G-1:0]  t1x, t2x, nm_new;
  logic          nn_new;
  logic          out_load;
  logic [G:0]    ntry, dtry;
  logic          nfit, dfit;
  logic          neg;
  logic [XN-1:0] num_x;
  logic [XD-1:0] den_x;

  logic          out_valid_q, out_err_q;
  logic [NumOutWidth-1:0] out_num_q;
  logic [DenOutWidth-1:0] out_den_q;

  // one shared multiplier, its product registered in StMul1, StMul2 and StMul3
  always_comb begin
    case (state_q)
      StMul1:  begin mul_a = am_q; mul_b = dm_q; end
      StMul2:  begin mul_a = cm_q; mul_b = bm_q; end
      default: begin mul_a = bm_q; mul_b = dm_q; end
    endcase
  end
  assign prod = PW'(mul_a * mul_b);

  // signed-magnitude combine of the two cross terms
  always_comb begin
    t1x = G'(t1_q);
    t2x = G'(t2_q);
    if (cls_q.t1_neg == cls_q.t2_neg) begin
      nn_new = cls_q.t1_neg;
      nm_new = t1x + t2x;
    end else if (t1x >= t2x) begin
      nn_new = cls_q.t1_neg;
      nm_new = t1x - t2x;
    end else begin
      nn_new = cls_q.t2_neg;
      nm_new = t2x - t1x;
    end
  end

  // restoring division step on both values
  assign ntry = {nrem_q, nsh_q[G-1]};
  assign dtry = {drem_q, dsh_q[G-1]};
  assign nfit = (ntry >= {1'b0, g_q});
  assign dfit = (dtry >= {1'b0, g_q});

  assign out_load = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == StIdle) && q_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (q_valid_i) state_d = class_i.zero_den ? StOut : StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StMul3;
      StMul3: state_d = StGcd;
      StGcd:  if ((x_q == '0) || (y_q == '0)) state_d = StDiv;
      StDiv:  if (cnt_q == KW'(G - 1)) state_d = StOut;
      StOut:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_load) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          cls_q <= class_i;
          am_q  <= mags_i[0*W +: W];
          bm_q  <= mags_i[1*W +: W];
          cm_q  <= mags_i[2*W +: W];
          dm_q  <= mags_i[3*W +: W];
        end
      end
      StMul1: t1_q <= prod;
      StMul2: t2_q <= prod;
      StMul3: begin
        nn_q  <= nn_new;
        x_q   <= nm_new;
        y_q   <= G'(prod);
        nsh_q <= nm_new;
        dsh_q <= G'(prod);
        k_q   <= '0;
      end
      StGcd: begin
        if ((x_q == '0) || (y_q == '0)) begin
          g_q    <= (x_q | y_q) << k_q;
          nrem_q <= '0;
          drem_q <= '0;
          cnt_q  <= '0;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + KW'(1);
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= (x_q - y_q) >> 1;
        end else begin
          y_q <= (y_q - x_q) >> 1;
        end
      end
      StDiv: begin
        nrem_q <= nfit ? G'(ntry - {1'b0, g_q}) : G'(ntry);
        drem_q <= dfit ? G'(dtry - {1'b0, g_q}) : G'(dtry);
        nsh_q  <= {nsh_q[G-2:0], nfit};
        dsh_q  <= {dsh_q[G-2:0], dfit};
        cnt_q  <= cnt_q + KW'(1);
      end
      default: ;
    endcase
  end

  // sign goes onto the numerator
  assign neg   = (nsh_q != '0) && (nn_q ^ cls_q.den_neg);
  assign num_x = neg ? (XN'(0) - XN'(nsh_q)) : XN'(nsh_q);
  assign den_x = XD'(dsh_q);

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && out_load) begin
      out_err_q <= cls_q.zero_den;
      out_num_q <= cls_q.zero_den ? '0 : num_x[NumOutWidth-1:0];
      out_den_q <= cls_q.zero_den ? '0 : den_x[DenOutWidth-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_num_o   = out_num_q;
  assign out_den_o   = out_den_q;
  assign out_err_o   = out_err_q;

endmodule

// ===== hw/rtl/frc_checker.sv =====
// port-level checks for the fraction add/subtract/reduce block, with bind
// depends on frc_pkg and the top level fraction_add_sub_reduce
module frc_checker import frc_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  logic [NumOutWidth-1:0] num;
  logic [DenOutWidth-1:0] den;
  assign num = m_axis_tdata_o[NumOutWidth-1:0];
  assign den = m_axis_tdata_o[63 -: DenOutWidth];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // error results read 0/0
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (num == '0) && (den == '0))
    else $error("error result not 0/0");

  // a good result never has a zero denominator
  a_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (den != '0))
    else $error("zero denominator without error");

  // zero reduces to 0/1
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o && (num == '0) |-> (den == DenOutWidth'(1)))
    else $error("zero not reduced to 0/1");

endmodule

bind fraction_add_sub_reduce frc_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_frc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
